[sv/kpsd_pkg.sv]
// ----------------------------------------------------------------------------
// kpsd_pkg
// Shared sizes, reset values and types for the keypad scan, debounce and
// long-press core.
// ----------------------------------------------------------------------------
package kpsd_pkg;

    // keypad geometry and debounce depth
    localparam int ROWS      = 4;
    localparam int COLS      = 4;
    localparam int DEB_LEN   = 8;
    localparam int NKEYS     = ROWS * COLS;

    // derived widths
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLS);
    localparam int KEY_IDX_W = $clog2(NKEYS);
    localparam int KEY_W     = $clog2(NKEYS + 1);
    localparam int CODE_W    = $clog2(2 * NKEYS + 1);

    // hold counter and threshold register
    localparam int                 CNT_W            = 8;
    localparam logic [CNT_W-1:0]   CNT_MAX          = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]   LONG_TICKS_RESET = CNT_W'(250);

    // stream payload sizes
    localparam int COL_LEVELS_W = 4;
    localparam int IN_FIELDS_W  = COL_LEVELS_W + 1;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + CODE_W + 1 + 1 + ROW_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // debounce status of the keys in the driven row after the new sample
    typedef struct packed {
        logic [COLS-1:0] all_low;
        logic [COLS-1:0] all_high;
    } t_col_status;

    // one result per scan tick
    typedef struct packed {
        logic              key_valid;
        logic [CODE_W-1:0] key_code;
        logic              short_beep;
        logic              long_beep;
        logic [ROW_W-1:0]  next_row;
    } t_key_result;

endpackage

[sv/kpsd_key_filter.sv]
// ----------------------------------------------------------------------------
// kpsd_key_filter
// Per-key sample history shift registers; flags keys of the driven row whose
// history reads steady low or steady high after the new sample.
// ----------------------------------------------------------------------------
module kpsd_key_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_update,
    input  logic [kpsd_pkg::ROW_W-1:0]        i_row,
    input  logic [kpsd_pkg::COL_LEVELS_W-1:0] i_col_levels,
    output kpsd_pkg::t_col_status             o_status
);
    import kpsd_pkg::*;

    logic [DEB_LEN-1:0] r_hist [NKEYS];
    logic [DEB_LEN-1:0] n_hist [COLS];

    // shift the new level into each key of the driven row
    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            n_hist[c] = {r_hist[KEY_IDX_W'(KEY_IDX_W'(i_row) * KEY_IDX_W'(COLS)
                                           + KEY_IDX_W'(c))][DEB_LEN-2:0],
                         i_col_levels[c]};
            o_status.all_low[c]  = (n_hist[c] == '0);
            o_status.all_high[c] = (&n_hist[c]);
        end
    end

    // history storage, released keys read all ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NKEYS; k++) begin
                r_hist[k] <= '1;
            end
        end else if (i_update) begin
            for (int c = 0; c < COLS; c++) begin
                r_hist[KEY_IDX_W'(KEY_IDX_W'(i_row) * KEY_IDX_W'(COLS)
                                  + KEY_IDX_W'(c))] <= n_hist[c];
            end
        end
    end

endmodule

[sv/kpsd_press_ctrl.sv]
// ----------------------------------------------------------------------------
// kpsd_press_ctrl
// Row scan pointer, pressed marks, press and hold tracking per row, shared
// hold counter and repeat latch; forms the key code and beep pulses.
// ----------------------------------------------------------------------------
module kpsd_press_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_update,
    input  logic                        i_repeat_due,
    input  logic [kpsd_pkg::CNT_W-1:0]  i_long_ticks,
    input  kpsd_pkg::t_col_status       i_status,
    output logic [kpsd_pkg::ROW_W-1:0]  o_row,
    output kpsd_pkg::t_key_result       o_result
);
    import kpsd_pkg::*;

    logic [ROW_W-1:0] r_row;
    logic [COLS-1:0]  r_marks [ROWS];
    logic [KEY_W-1:0] r_press [ROWS];
    logic [KEY_W-1:0] r_hold  [ROWS];
    logic [ROWS-1:0]  r_timing;
    logic [CNT_W-1:0] r_hold_cnt;
    logic             r_repeat;

    logic [ROW_W-1:0]  n_row;
    logic [COLS-1:0]   n_marks;
    logic [KEY_W-1:0]  n_press;
    logic [KEY_W-1:0]  n_hold;
    logic [ROWS-1:0]   n_timing;
    logic [CNT_W-1:0]  n_hold_cnt;
    logic              n_repeat;

    logic [COLS-1:0]   cur_marks;
    logic [COLS-1:0]   qualify;
    logic [COL_W-1:0]  win_col;
    logic [KEY_W-1:0]  new_key;
    logic              have;
    logic              is_long;
    logic              lbeep;
    logic [CODE_W-1:0] code;

    assign o_row = r_row;

    // debounce qualify and highest-column pick
    always_comb begin
        cur_marks = r_marks[r_row];
        qualify   = '0;
        win_col   = '0;
        for (int c = 0; c < COLS; c++) begin
            qualify[c] = !cur_marks[c] && i_status.all_low[c];
            if (qualify[c]) begin
                win_col = COL_W'(c);
            end
        end
        new_key = KEY_W'(KEY_W'(r_row) * KEY_W'(COLS) + KEY_W'(win_col) + KEY_W'(1));
    end

    // press, hold and long-press decisions for the driven row
    always_comb begin
        n_repeat   = r_repeat | i_repeat_due;
        n_hold_cnt = r_hold_cnt;
        if ((r_timing != '0) && (r_hold_cnt != CNT_MAX)) begin
            n_hold_cnt = r_hold_cnt + CNT_W'(1);
        end
        n_timing = r_timing;
        n_press  = r_press[r_row];
        n_hold   = r_hold[r_row];
        for (int c = 0; c < COLS; c++) begin
            if (qualify[c]) begin
                n_marks[c] = 1'b1;
            end else if (i_status.all_high[c]) begin
                n_marks[c] = 1'b0;
            end else begin
                n_marks[c] = cur_marks[c];
            end
        end
        have    = |qualify;
        is_long = 1'b0;
        lbeep   = 1'b0;
        code    = CODE_W'(new_key);

        if (r_hold[r_row] != '0) begin
            // key already in long press
            if (!have || (new_key != r_hold[r_row])) begin
                n_hold  = '0;
                n_press = '0;
            end else begin
                is_long          = 1'b1;
                n_marks[win_col] = 1'b0;
                code             = CODE_W'(r_hold[r_row]) + CODE_W'(NKEYS);
            end
        end else if (have) begin
            // new or continuing press
            if (!r_timing[r_row]) begin
                n_press           = new_key;
                n_hold_cnt        = '0;
                n_timing[r_row]   = 1'b1;
            end else if (new_key == r_press[r_row]) begin
                have = 1'b0;
            end else begin
                n_press    = new_key;
                n_hold_cnt = '0;
            end
            n_marks[win_col] = 1'b0;
            if (n_hold_cnt >= i_long_ticks) begin
                n_timing[r_row] = 1'b0;
                n_hold          = n_press;
                code            = CODE_W'(n_press) + CODE_W'(NKEYS);
                have            = 1'b1;
                is_long         = 1'b1;
                lbeep           = 1'b1;
            end
        end else begin
            // nothing held in this row
            n_hold          = '0;
            n_press         = '0;
            n_timing[r_row] = 1'b0;
        end

        // long codes go out only against a pending repeat
        if (have && is_long) begin
            if (n_repeat) begin
                n_repeat = 1'b0;
            end else begin
                have = 1'b0;
            end
        end

        n_row = (r_row == ROW_W'(ROWS - 1)) ? '0 : r_row + ROW_W'(1);

        o_result.key_valid  = have;
        o_result.key_code   = have ? code : '0;
        o_result.short_beep = have && !is_long;
        o_result.long_beep  = lbeep;
        o_result.next_row   = n_row;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_timing   <= '0;
            r_hold_cnt <= '0;
            r_repeat   <= 1'b0;
            for (int r = 0; r < ROWS; r++) begin
                r_marks[r] <= '0;
                r_press[r] <= '0;
                r_hold[r]  <= '0;
            end
        end else if (i_update) begin
            r_row          <= n_row;
            r_timing       <= n_timing;
            r_hold_cnt     <= n_hold_cnt;
            r_repeat       <= n_repeat;
            r_marks[r_row] <= n_marks;
            r_press[r_row] <= n_press;
            r_hold[r_row]  <= n_hold;
        end
    end

endmodule

[sv/keypad_scan_debounce_long_press_core.sv]
// ----------------------------------------------------------------------------
// keypad_scan_debounce_long_press_core
// Matrix keypad scan tick processor with per-key debounce, short press codes,
// long press codes and repeats.
// ----------------------------------------------------------------------------
// Each input request is one scan tick: the column levels of the row named by
// the previous result's next_row, and a repeat-due pulse. Each tick yields
// exactly one result request. A tick is registered at the input, then processed
// through the history and press logic into the output register; one tick is
// taken every cycle while results are drained; the output and input registers
// together decouple the two sides under backpressure. long_press_ticks is
// written through the cfg channel, which is always ready; the user must write
// it only while no tick is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_long_press_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tick in: [3:0] col_levels, [4] repeat_due
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [kpsd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // result out: [0] key_valid, [6:1] key_code, [7] short_beep,
    // [8] long_beep, [10:9] next_row
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [kpsd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // long_press_ticks write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kpsd_pkg::CNT_W-1:0]       i_cfg_data
);
    import kpsd_pkg::*;

    logic                    r_in_valid;
    logic [COL_LEVELS_W-1:0] r_in_cols;
    logic                    r_in_repeat;
    logic                    r_out_valid;
    t_key_result             r_out;
    logic [CNT_W-1:0]        r_long_ticks;

    logic                    fire;
    logic [ROW_W-1:0]        scan_row;
    t_col_status             col_status;
    t_key_result             result;

    // process the held tick when the output register is free
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out.next_row, r_out.long_beep, r_out.short_beep,
                                        r_out.key_code, r_out.key_valid});

    kpsd_key_filter u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_update     (fire),
        .i_row        (scan_row),
        .i_col_levels (r_in_cols),
        .o_status     (col_status)
    );

    kpsd_press_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_update     (fire),
        .i_repeat_due (r_in_repeat),
        .i_long_ticks (r_long_ticks),
        .i_status     (col_status),
        .o_row        (scan_row),
        .o_result     (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cols   <= s_axis_tdata[COL_LEVELS_W-1:0];
            r_in_repeat <= s_axis_tdata[COL_LEVELS_W];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    // long press threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks <= LONG_TICKS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_long_ticks <= i_cfg_data;
        end
    end

endmodule
